FILE: hdl/text_console_writer_defines.svh
// Assertion helpers for the checker file of the text console writer.
// Every property is sampled on the rising clock edge and is switched off while
// reset is high.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// The consequent must hold at the same edge as the antecedent.
`define TCW_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("text console writer check failed");

// The consequent must hold at the edge after the antecedent.
`define TCW_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("text console writer check failed");

`endif

FILE: hdl/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

   // Screen geometry.
   localparam int COLUMNS_PER_ROW = 80;
   localparam int ROWS            = 25;
   localparam int CELL_COUNT      = COLUMNS_PER_ROW * ROWS;
   localparam int SHIFT_CELLS     = (ROWS - 1) * COLUMNS_PER_ROW;

   // Internal widths that follow from the geometry.
   localparam int COL_W  = $clog2(COLUMNS_PER_ROW);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int ADDR_W = $clog2(CELL_COUNT);

   // Field widths of the channels.
   localparam int CMD_W     = 3;
   localparam int CHAR_W    = 8;
   localparam int IN_COL_W  = 8;
   localparam int IN_ROW_W  = 6;
   localparam int OUT_COL_W = 7;
   localparam int OUT_ROW_W = 5;
   localparam int ATTR_W    = 8;
   localparam int CELL_W    = ATTR_W + CHAR_W;

   // Register port.
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_TEXT_ATTRIBUTE = 2'd0;
   localparam logic [ATTR_W-1:0]     ATTR_RESET              = 8'h07;

   // Depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_PUT_CHAR    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_CLEAR       = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SCROLL_UP   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SCROLL_DOWN = 3'd3;
   localparam logic [CMD_W-1:0] CMD_GOTO        = 3'd4;
   localparam logic [CMD_W-1:0] CMD_READ        = 3'd5;

   // Characters that start a new line.
   localparam logic [CHAR_W-1:0] CHAR_LF = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_CR = 8'd13;

   // Operations as the front classifies them.
   typedef enum logic [2:0] {
      OP_PUT,
      OP_NEWLINE,
      OP_CLEAR,
      OP_SCROLL_UP,
      OP_SCROLL_DOWN,
      OP_GOTO,
      OP_READ,
      OP_NOP
   } tcw_op_type;

   // One classified command as it waits in the queue.
   typedef struct packed {
      tcw_op_type        op;
      logic [CHAR_W-1:0] ch;
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
      logic [ADDR_W-1:0] addr;
      logic              rejected;
   } tcw_entry_type;

endpackage

`default_nettype wire

FILE: hdl/tcw_ifs.sv
`default_nettype none

// Command channel.
interface tcw_req_if;
   import tcw_pkg::*;

   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [CHAR_W-1:0]   char_code;
   logic [IN_COL_W-1:0] col;
   logic [IN_ROW_W-1:0] row;

   modport source (output valid, cmd, char_code, col, row, input ready);
   modport sink   (input valid, cmd, char_code, col, row, output ready);
endinterface

// Result channel.
interface tcw_rsp_if;
   import tcw_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [OUT_COL_W-1:0] cursor_col;
   logic [OUT_ROW_W-1:0] cursor_row;
   logic [CELL_W-1:0]    cell_data;
   logic                 position_rejected;

   modport source (output valid, cursor_col, cursor_row, cell_data, position_rejected,
                   input ready);
   modport sink   (input valid, cursor_col, cursor_row, cell_data, position_rejected,
                   output ready);
endinterface

`default_nettype wire

FILE: hdl/tcw_ram.sv
`default_nettype none

module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: hdl/tcw_front.sv
`default_nettype none

module tcw_front (
   tcw_req_if.sink                req_ch,
   input  logic                   init_busy,
   input  logic                   queue_full,
   output logic                   push,
   output tcw_pkg::tcw_entry_type push_entry
);
   import tcw_pkg::*;

   logic on_screen;
   logic is_newline;

   // A command is taken whenever the queue has room and the clearing pass after reset is not running.
   assign req_ch.ready = !queue_full && !init_busy;
   assign push         = req_ch.valid && req_ch.ready;

   // Classify the command and precompute the cell address for a read.
   always_comb begin
      on_screen  = (32'(req_ch.col) < COLUMNS_PER_ROW) && (32'(req_ch.row) < ROWS);
      is_newline = (req_ch.char_code == CHAR_LF) || (req_ch.char_code == CHAR_CR);

      push_entry.ch       = req_ch.char_code;
      push_entry.col      = COL_W'(req_ch.col);
      push_entry.row      = ROW_W'(req_ch.row);
      push_entry.addr     = ADDR_W'(req_ch.row) * ADDR_W'(COLUMNS_PER_ROW)
                          + ADDR_W'(req_ch.col);
      push_entry.rejected = 1'b0;
      push_entry.op       = OP_NOP;

      unique case (req_ch.cmd)
         CMD_PUT_CHAR: begin
            push_entry.op = is_newline ? OP_NEWLINE : OP_PUT;
         end
         CMD_CLEAR: begin
            push_entry.op = OP_CLEAR;
         end
         CMD_SCROLL_UP: begin
            push_entry.op = OP_SCROLL_UP;
         end
         CMD_SCROLL_DOWN: begin
            push_entry.op = OP_SCROLL_DOWN;
         end
         CMD_GOTO: begin
            // An off-screen goto leaves the cursor alone and only reports.
            push_entry.op       = on_screen ? OP_GOTO : OP_NOP;
            push_entry.rejected = !on_screen;
         end
         CMD_READ: begin
            push_entry.op       = on_screen ? OP_READ : OP_NOP;
            push_entry.rejected = !on_screen;
         end
         default: begin
            push_entry.op = OP_NOP;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: hdl/tcw_queue.sv
`default_nettype none

module tcw_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  tcw_pkg::tcw_entry_type push_entry,
   input  logic                   pop,
   output logic                   full,
   output logic                   not_empty,
   output tcw_pkg::tcw_entry_type head
);
   import tcw_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   tcw_entry_type    entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wptr_ff, wptr_in;
   logic [PTR_W-1:0] rptr_ff, rptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entries_ff[rptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = (wptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (pop) begin
         rptr_in = (rptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/tcw_back.sv
`default_nettype none

module tcw_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [tcw_pkg::ATTR_W-1:0]  text_attribute,
   input  logic                        q_not_empty,
   input  tcw_pkg::tcw_entry_type      head,
   output logic                        pop,
   output logic                        init_busy,
   tcw_rsp_if.source                   rsp_ch
);
   import tcw_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_READ   = 5'b00010,
      ST_SHIFT  = 5'b00100,
      ST_ZERO   = 5'b01000,
      ST_FINISH = 5'b10000
   } tcw_state_type;

   tcw_state_type        state_ff, state_in;
   logic [COL_W-1:0]     cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]     cur_row_ff, cur_row_in;
   logic [ADDR_W-1:0]    ptr_ff, ptr_in;
   logic [ADDR_W-1:0]    zero_last_ff, zero_last_in;
   logic [ADDR_W-1:0]    wr_addr_ff, wr_addr_in;
   logic                 wpend_ff, wpend_in;
   logic                 dir_down_ff, dir_down_in;
   logic                 silent_ff, silent_in;
   logic [CELL_W-1:0]    pend_data_ff, pend_data_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [OUT_COL_W-1:0] rsp_col_ff, rsp_col_in;
   logic [OUT_ROW_W-1:0] rsp_row_ff, rsp_row_in;
   logic [CELL_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                 rsp_rej_ff, rsp_rej_in;

   logic                 ram_wr_en;
   logic [ADDR_W-1:0]    ram_wr_addr;
   logic [CELL_W-1:0]    ram_wr_data;
   logic                 ram_rd_en;
   logic [ADDR_W-1:0]    ram_rd_addr;
   logic [CELL_W-1:0]    ram_rd_data;

   logic                 out_free;
   logic [ADDR_W-1:0]    cur_addr;
   logic                 at_last_col;
   logic                 at_last_row;
   logic                 shift_more;
   logic                 finish_now;
   logic                 result_rej;
   logic                 start_shift;
   logic                 start_down;

   // Cell store.
   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELL_COUNT)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Cursor position and helpers.
   assign cur_addr    = ADDR_W'(cur_row_ff) * ADDR_W'(COLUMNS_PER_ROW) + ADDR_W'(cur_col_ff);
   assign at_last_col = (cur_col_ff == COL_W'(COLUMNS_PER_ROW - 1));
   assign at_last_row = (cur_row_ff == ROW_W'(ROWS - 1));
   assign out_free    = !rsp_valid_ff || rsp_ch.ready;
   assign shift_more  = dir_down_ff ? (ptr_ff >= ADDR_W'(COLUMNS_PER_ROW))
                                    : (ptr_ff < ADDR_W'(SHIFT_CELLS));
   assign init_busy   = silent_ff;

   // Command sequencer.
   always_comb begin
      state_in     = state_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      ptr_in       = ptr_ff;
      zero_last_in = zero_last_ff;
      wr_addr_in   = wr_addr_ff;
      wpend_in     = wpend_ff;
      dir_down_in  = dir_down_ff;
      silent_in    = silent_ff;
      pend_data_in = pend_data_ff;
      pop          = 1'b0;
      finish_now   = 1'b0;
      result_rej   = 1'b0;
      start_shift  = 1'b0;
      start_down   = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = ptr_ff;
      ram_wr_data  = '0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = head.addr;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_not_empty && out_free) begin
               pop          = 1'b1;
               pend_data_in = '0;
               result_rej   = head.rejected;
               unique case (head.op)
                  OP_PUT: begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = cur_addr;
                     ram_wr_data = {text_attribute, head.ch};
                     if (!at_last_col) begin
                        cur_col_in = cur_col_ff + 1'b1;
                        finish_now = 1'b1;
                     end else begin
                        cur_col_in = '0;
                        if (!at_last_row) begin
                           cur_row_in = cur_row_ff + 1'b1;
                           finish_now = 1'b1;
                        end else begin
                           start_shift = 1'b1;
                        end
                     end
                  end
                  OP_NEWLINE: begin
                     cur_col_in = '0;
                     if (!at_last_row) begin
                        cur_row_in = cur_row_ff + 1'b1;
                        finish_now = 1'b1;
                     end else begin
                        start_shift = 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     cur_col_in   = '0;
                     cur_row_in   = '0;
                     ptr_in       = '0;
                     zero_last_in = ADDR_W'(CELL_COUNT - 1);
                     state_in     = ST_ZERO;
                  end
                  OP_SCROLL_UP: begin
                     start_shift = 1'b1;
                  end
                  OP_SCROLL_DOWN: begin
                     start_shift = 1'b1;
                     start_down  = 1'b1;
                  end
                  OP_GOTO: begin
                     cur_col_in = head.col;
                     cur_row_in = head.row;
                     finish_now = 1'b1;
                  end
                  OP_READ: begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = head.addr;
                     state_in    = ST_READ;
                  end
                  default: begin
                     finish_now = 1'b1;
                  end
               endcase
               if (start_shift) begin
                  dir_down_in = start_down;
                  ptr_in      = start_down ? ADDR_W'(CELL_COUNT - 1) : '0;
                  wpend_in    = 1'b0;
                  state_in    = ST_SHIFT;
               end
            end
         end
         ST_READ: begin
            pend_data_in = ram_rd_data;
            state_in     = ST_FINISH;
         end
         ST_SHIFT: begin
            // Read one row ahead of the write, one cell per cycle.
            if (wpend_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = wr_addr_ff;
               ram_wr_data = ram_rd_data;
            end
            if (shift_more) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = dir_down_ff ? ptr_ff - ADDR_W'(COLUMNS_PER_ROW)
                                         : ptr_ff + ADDR_W'(COLUMNS_PER_ROW);
               wr_addr_in  = ptr_ff;
               wpend_in    = 1'b1;
               ptr_in      = dir_down_ff ? ptr_ff - 1'b1 : ptr_ff + 1'b1;
            end else begin
               // The last copy is written now; blank the freed row next.
               wpend_in     = 1'b0;
               ptr_in       = dir_down_ff ? '0 : ADDR_W'(SHIFT_CELLS);
               zero_last_in = dir_down_ff ? ADDR_W'(COLUMNS_PER_ROW - 1)
                                          : ADDR_W'(CELL_COUNT - 1);
               state_in     = ST_ZERO;
            end
         end
         ST_ZERO: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = ptr_ff;
            ram_wr_data = '0;
            if (ptr_ff == zero_last_ff) begin
               // The clearing pass after reset produces no result.
               silent_in = 1'b0;
               state_in  = silent_ff ? ST_IDLE : ST_FINISH;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               finish_now = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result register: loads when a command completes, empties on a transfer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_rej_in   = rsp_rej_ff;
      if (finish_now) begin
         rsp_valid_in = 1'b1;
         rsp_col_in   = OUT_COL_W'(cur_col_in);
         rsp_row_in   = OUT_ROW_W'(cur_row_in);
         rsp_data_in  = pend_data_in;
         rsp_rej_in   = result_rej;
      end
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.cursor_col        = rsp_col_ff;
   assign rsp_ch.cursor_row        = rsp_row_ff;
   assign rsp_ch.cell_data         = rsp_data_ff;
   assign rsp_ch.position_rejected = rsp_rej_ff;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ZERO;
         silent_ff    <= 1'b1;
         ptr_ff       <= '0;
         zero_last_ff <= ADDR_W'(CELL_COUNT - 1);
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         wpend_ff     <= 1'b0;
         dir_down_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         silent_ff    <= silent_in;
         ptr_ff       <= ptr_in;
         zero_last_ff <= zero_last_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         wpend_ff     <= wpend_in;
         dir_down_ff  <= dir_down_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      wr_addr_ff   <= wr_addr_in;
      pend_data_ff <= pend_data_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_rej_ff   <= rsp_rej_in;
   end

endmodule

`default_nettype wire

FILE: hdl/text_console_writer.sv
// Text console writer: a character cell store of ROWS x COLUMNS_PER_ROW 16-bit
// cells (attribute in the high byte, character in the low byte) with a cursor,
// driven by one command per transfer on req_ch and answering with one result
// per command on rsp_ch (cursor after the command, the cell read, and a reject
// flag for off-screen goto or read). Commands enter a two-entry queue and are
// carried out in order by a sequencer that owns the single-port-write cell
// memory. Put-char, newline, goto and unused codes complete in the idle state
// of the sequencer, so a steady stream of characters moves at one command per
// cycle while results are taken; read passes through a read state and a finish
// state. Scroll up and scroll down copy one cell per cycle and then blank the
// freed row before loading their result; a put-char or newline that runs off
// the last row does the same. Clear blanks all CELL_COUNT cells before loading
// its result. After reset the block clears the store and holds req_ch.ready
// low meanwhile; register writes are taken at any time. The text_attribute
// register sits at address 0 of the csr_ port.
`default_nettype none

module text_console_writer (
   input  logic                             clock,
   input  logic                             reset,
   tcw_req_if.sink                          req_ch,
   tcw_rsp_if.source                        rsp_ch,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [tcw_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [tcw_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [tcw_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import tcw_pkg::*;

   logic [ATTR_W-1:0] text_attribute_ff, text_attribute_in;
   logic              csr_write;
   logic              init_busy;
   logic              queue_full;
   logic              queue_not_empty;
   logic              push;
   logic              pop;
   tcw_entry_type     push_entry;
   tcw_entry_type     head;

   // Register port: never inserts wait states.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                    && (csr_paddr == CSR_ADDR_TEXT_ATTRIBUTE);
   assign csr_prdata = (csr_paddr == CSR_ADDR_TEXT_ATTRIBUTE) ?
                       CSR_DATA_W'(text_attribute_ff) : '0;
   assign text_attribute_in = csr_write ? csr_pwdata[ATTR_W-1:0] : text_attribute_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         text_attribute_ff <= ATTR_RESET;
      end else begin
         text_attribute_ff <= text_attribute_in;
      end
   end

   // Command intake and classification.
   tcw_front u_front (
      .req_ch     (req_ch),
      .init_busy  (init_busy),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // Queue between intake and execution.
   tcw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .not_empty  (queue_not_empty),
      .head       (head)
   );

   // Execution against the cell store.
   tcw_back u_back (
      .clock          (clock),
      .reset          (reset),
      .text_attribute (text_attribute_ff),
      .q_not_empty    (queue_not_empty),
      .head           (head),
      .pop            (pop),
      .init_busy      (init_busy),
      .rsp_ch         (rsp_ch)
   );

endmodule

`default_nettype wire

FILE: hdl/tcw_checker.sv
`default_nettype none
`include "text_console_writer_defines.svh"

module tcw_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [tcw_pkg::OUT_COL_W-1:0]    rsp_cursor_col,
   input logic [tcw_pkg::OUT_ROW_W-1:0]    rsp_cursor_row,
   input logic [tcw_pkg::CELL_W-1:0]       rsp_cell_data,
   input logic                             rsp_position_rejected,
   input logic                             csr_psel,
   input logic                             csr_penable,
   input logic                             csr_pwrite,
   input logic                             csr_pready,
   input logic [tcw_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input logic [tcw_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   input logic [tcw_pkg::CSR_DATA_W-1:0]   csr_prdata
);
   import tcw_pkg::*;

   // The store is being cleared right after reset, so no command is taken.
   `TCW_ASSERT_SAME(a_no_intake_after_reset, $fell(reset), !req_ready)

   // A stalled result keeps its contents until it is transferred.
   `TCW_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_cursor_col) && $stable(rsp_cursor_row) && $stable(rsp_cell_data) && $stable(rsp_position_rejected))

   // A rejected position never carries cell contents.
   `TCW_ASSERT_SAME(a_reject_no_data, rsp_valid && rsp_position_rejected, rsp_cell_data == '0)

   // A written attribute reads back on the next cycle.
   `TCW_ASSERT_NEXT(a_attr_readback, csr_psel && csr_penable && csr_pwrite && csr_pready && (csr_paddr == CSR_ADDR_TEXT_ATTRIBUTE), (csr_paddr != CSR_ADDR_TEXT_ATTRIBUTE) || (csr_prdata[ATTR_W-1:0] == $past(csr_pwdata[ATTR_W-1:0])))

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_ready             (req_ch.ready),
   .rsp_valid             (rsp_ch.valid),
   .rsp_ready             (rsp_ch.ready),
   .rsp_cursor_col        (rsp_ch.cursor_col),
   .rsp_cursor_row        (rsp_ch.cursor_row),
   .rsp_cell_data         (rsp_ch.cell_data),
   .rsp_position_rejected (rsp_ch.position_rejected),
   .csr_psel              (csr_psel),
   .csr_penable           (csr_penable),
   .csr_pwrite            (csr_pwrite),
   .csr_pready            (csr_pready),
   .csr_paddr             (csr_paddr),
   .csr_pwdata            (csr_pwdata),
   .csr_prdata            (csr_prdata)
);

`default_nettype wire

FILE: dv/tb_text_console_writer.sv
`default_nettype none

module tb_text_console_writer;
   timeunit 1ns;
   timeprecision 1ps;

   import tcw_pkg::*;

   // Command codes that the block leaves unused.
   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

   localparam int PHASES          = 5;
   localparam int ITEMS_PER_PHASE = 220;
   localparam int SETTLE_CYCLES   = 8;
   // The limit covers a scroll or the clearing pass after reset, plus the long
   // receiver hold-off.
   localparam int WATCHDOG_LIMIT  = 20000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int HOLD_OFF_AFTER  = 500;

   typedef struct packed {
      logic [OUT_COL_W-1:0] cursor_col;
      logic [OUT_ROW_W-1:0] cursor_row;
      logic [CELL_W-1:0]    cell_data;
      logic                 position_rejected;
   } console_reply_type;

   typedef struct {
      logic [CMD_W-1:0]    cmd;
      logic [CHAR_W-1:0]   ch;
      logic [IN_COL_W-1:0] col;
      logic [IN_ROW_W-1:0] row;
      bit                  typed;
      console_reply_type   reply;
   } directed_row_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   tcw_req_if req_ch ();
   tcw_rsp_if rsp_ch ();

   text_console_writer uut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Shadow copy of the screen, the cursor and the attribute register.
   logic [CELL_W-1:0] screen [CELL_COUNT];
   int                cursor_x;
   int                cursor_y;
   logic [ATTR_W-1:0] text_attr;

   console_reply_type queued_replies [$];
   int                failures;
   int                replies_seen;
   int                idle_cycles = 0;
   bit                steady_flow;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Shift every row up by one and blank the bottom row.
   function automatic void scroll_screen_up();
      for (int i = 0; i < SHIFT_CELLS; i++) screen[i] = screen[i + COLUMNS_PER_ROW];
      for (int i = SHIFT_CELLS; i < CELL_COUNT; i++) screen[i] = '0;
   endfunction

   function automatic void advance_line();
      cursor_x = 0;
      cursor_y++;
      if (cursor_y >= ROWS) begin
         cursor_y = ROWS - 1;
         scroll_screen_up();
      end
   endfunction

   // Apply one command to the shadow console and return the reply it yields.
   function automatic console_reply_type console_apply(logic [CMD_W-1:0] cmd,
         logic [CHAR_W-1:0] ch, logic [IN_COL_W-1:0] col, logic [IN_ROW_W-1:0] row);
      console_reply_type reply;
      int                c;
      int                r;
      bit                on_screen;
      reply     = '0;
      c         = int'(col);
      r         = int'(row);
      on_screen = (c < COLUMNS_PER_ROW) && (r < ROWS);
      case (cmd)
         CMD_PUT_CHAR: begin
            if (ch == CHAR_LF || ch == CHAR_CR) begin
               advance_line();
            end else begin
               screen[cursor_y * COLUMNS_PER_ROW + cursor_x] = {text_attr, ch};
               cursor_x++;
               if (cursor_x >= COLUMNS_PER_ROW) advance_line();
            end
         end
         CMD_CLEAR: begin
            foreach (screen[i]) screen[i] = '0;
            cursor_x = 0;
            cursor_y = 0;
         end
         CMD_SCROLL_UP: begin
            scroll_screen_up();
         end
         CMD_SCROLL_DOWN: begin
            for (int i = CELL_COUNT - 1; i >= COLUMNS_PER_ROW; i--)
               screen[i] = screen[i - COLUMNS_PER_ROW];
            for (int i = 0; i < COLUMNS_PER_ROW; i++) screen[i] = '0;
         end
         CMD_GOTO: begin
            if (on_screen) begin
               cursor_x = c;
               cursor_y = r;
            end else begin
               reply.position_rejected = 1'b1;
            end
         end
         CMD_READ: begin
            if (on_screen) reply.cell_data = screen[r * COLUMNS_PER_ROW + c];
            else reply.position_rejected = 1'b1;
         end
         default: begin
         end
      endcase
      reply.cursor_col = OUT_COL_W'(cursor_x);
      reply.cursor_row = OUT_ROW_W'(cursor_y);
      return reply;
   endfunction

   function automatic directed_row_type pred_row(logic [CMD_W-1:0] cmd, int ch, int col,
         int row);
      directed_row_type line;
      line.cmd   = cmd;
      line.ch    = CHAR_W'(ch);
      line.col   = IN_COL_W'(col);
      line.row   = IN_ROW_W'(row);
      line.typed = 1'b0;
      line.reply = '0;
      return line;
   endfunction

   function automatic directed_row_type typed_row(logic [CMD_W-1:0] cmd, int ch, int col,
         int row, int want_col, int want_row, int want_data, bit want_rejected);
      directed_row_type line;
      line       = pred_row(cmd, ch, col, row);
      line.typed = 1'b1;
      line.reply = '{OUT_COL_W'(want_col), OUT_ROW_W'(want_row), CELL_W'(want_data),
                     want_rejected};
      return line;
   endfunction

   // Idle length: mostly none or short, now and then long.
   function automatic int pick_gap();
      int roll;
      if (steady_flow) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void note_failure(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
   endfunction

   // Offer one command and wait for its transfer; valid stays high afterwards so that
   // a back-to-back command can follow in the same step.
   task automatic send_command(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
         logic [IN_COL_W-1:0] col, logic [IN_ROW_W-1:0] row, bit typed,
         console_reply_type typed_reply);
      int                gap;
      console_reply_type predicted;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.cmd       <= cmd;
      req_ch.char_code <= ch;
      req_ch.col       <= col;
      req_ch.row       <= row;
      do @(posedge clock); while (!req_ch.ready);
      predicted = console_apply(cmd, ch, col, row);
      queued_replies.push_back(typed ? typed_reply : predicted);
   endtask

   task automatic write_text_attribute(logic [ATTR_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_TEXT_ATTRIBUTE;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      text_attr = value;
   endtask

   // Wait until every expected reply has come back, then let the block go quiet.
   task automatic settle();
      while (queued_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Compare one reply transfer, field by field, with the oldest expectation.
   task automatic check_reply();
      console_reply_type got;
      console_reply_type want;
      string             bad;
      got = '{rsp_ch.cursor_col, rsp_ch.cursor_row, rsp_ch.cell_data,
              rsp_ch.position_rejected};
      replies_seen++;
      if (queued_replies.size() == 0) begin
         note_failure($sformatf("reply %0d arrived with nothing expected: col %0d row %0d %h %b",
                                replies_seen, got.cursor_col, got.cursor_row, got.cell_data,
                                got.position_rejected));
         return;
      end
      want = queued_replies.pop_front();
      bad  = "";
      if (got.cursor_col !== want.cursor_col) bad = {bad, " cursor_col"};
      if (got.cursor_row !== want.cursor_row) bad = {bad, " cursor_row"};
      if (got.cell_data !== want.cell_data) bad = {bad, " cell_data"};
      if (got.position_rejected !== want.position_rejected) bad = {bad, " position_rejected"};
      if (bad != "")
         note_failure($sformatf(
            "reply %0d mismatch in%s: expected col %0d row %0d data %h rej %b, got %0d %0d %h %b",
            replies_seen, bad, want.cursor_col, want.cursor_row, want.cell_data,
            want.position_rejected, got.cursor_col, got.cursor_row, got.cell_data,
            got.position_rejected));
   endtask

   // Reply side: random stalls, plus one long hold-off that backs the block up.
   initial begin : reply_sink
      int hold_left;
      bit held_once;
      hold_left = 0;
      held_once = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) check_reply();
         if (!held_once && replies_seen >= HOLD_OFF_AFTER) begin
            held_once = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) hold_left = pick_gap();
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin : command_source
      directed_row_type  plan [$];
      logic [CMD_W-1:0]  cmd;
      logic [CHAR_W-1:0] ch;
      logic [IN_COL_W-1:0] col;
      logic [IN_ROW_W-1:0] row;
      logic [ATTR_W-1:0] attr;
      int                burst_left;
      int                roll;

      failures     = 0;
      replies_seen = 0;
      steady_flow  = 1'b0;
      burst_left   = 0;
      foreach (screen[i]) screen[i] = '0;
      cursor_x  = 0;
      cursor_y  = 0;
      text_attr = ATTR_RESET;

      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.cmd       <= CMD_PUT_CHAR;
      req_ch.char_code <= '0;
      req_ch.col       <= '0;
      req_ch.row       <= '0;
      csr_psel         <= 1'b0;
      csr_penable      <= 1'b0;
      csr_pwrite       <= 1'b0;
      csr_paddr        <= '0;
      csr_pwdata       <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part with the reset attribute: cursor motion, wrap and scroll at the
      // bottom, rejected positions, unused codes, scrolls and clear.
      plan.push_back(typed_row(CMD_READ, 0, 0, 0, 0, 0, 16'h0000, 0));
      plan.push_back(typed_row(CMD_PUT_CHAR, 8'h41, 255, 63, 1, 0, 0, 0));
      plan.push_back(typed_row(CMD_READ, 0, 0, 0, 1, 0, 16'h0741, 0));
      plan.push_back(pred_row(CMD_PUT_CHAR, 8'hFF, 0, 0));
      plan.push_back(pred_row(CMD_PUT_CHAR, 8'h00, 0, 0));
      plan.push_back(typed_row(CMD_PUT_CHAR, CHAR_LF, 0, 0, 0, 1, 0, 0));
      plan.push_back(typed_row(CMD_PUT_CHAR, CHAR_CR, 0, 0, 0, 2, 0, 0));
      plan.push_back(typed_row(CMD_GOTO, 0, 79, 24, 79, 24, 0, 0));
      plan.push_back(typed_row(CMD_PUT_CHAR, 8'h5A, 0, 0, 0, 24, 0, 0));
      plan.push_back(typed_row(CMD_READ, 0, 79, 23, 0, 24, 16'h075A, 0));
      plan.push_back(typed_row(CMD_GOTO, 0, 80, 0, 0, 24, 0, 1));
      plan.push_back(typed_row(CMD_GOTO, 0, 0, 25, 0, 24, 0, 1));
      plan.push_back(typed_row(CMD_GOTO, 0, 255, 63, 0, 24, 0, 1));
      plan.push_back(typed_row(CMD_READ, 0, 255, 63, 0, 24, 0, 1));
      plan.push_back(typed_row(CMD_READ, 0, 80, 3, 0, 24, 0, 1));
      plan.push_back(typed_row(CMD_SPARE_LO, 8'hFF, 255, 63, 0, 24, 0, 0));
      plan.push_back(typed_row(CMD_SPARE_HI, 0, 0, 0, 0, 24, 0, 0));
      plan.push_back(pred_row(CMD_SCROLL_DOWN, 0, 0, 0));
      plan.push_back(pred_row(CMD_READ, 0, 79, 24));
      plan.push_back(pred_row(CMD_SCROLL_UP, 0, 0, 0));
      plan.push_back(typed_row(CMD_GOTO, 0, 0, 0, 0, 0, 0, 0));
      plan.push_back(pred_row(CMD_READ, 0, 1, 0));
      plan.push_back(typed_row(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0));
      plan.push_back(typed_row(CMD_READ, 0, 79, 23, 0, 0, 0, 0));
      plan.push_back(typed_row(CMD_GOTO, 0, 0, 24, 0, 24, 0, 0));
      plan.push_back(pred_row(CMD_PUT_CHAR, CHAR_LF, 0, 0));
      foreach (plan[i])
         send_command(plan[i].cmd, plan[i].ch, plan[i].col, plan[i].row, plan[i].typed,
                      plan[i].reply);
      req_ch.valid <= 1'b0;

      // Random phases, each under its own attribute; the middle one runs without idling.
      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         attr = (phase == 0) ? 8'hFF : (phase == 1) ? 8'h00 : ATTR_W'($urandom_range(1, 254));
         write_text_attribute(attr);
         steady_flow = (phase == 2);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            col = IN_COL_W'($urandom_range(0, 255));
            row = IN_ROW_W'($urandom_range(0, 63));
            ch  = CHAR_W'($urandom_range(0, 255));
            if (burst_left == 0 && $urandom_range(0, 19) == 0)
               burst_left = $urandom_range(60, 120);
            if (burst_left > 0) begin
               // A run of text long enough to wrap lines.
               burst_left--;
               cmd = CMD_PUT_CHAR;
               ch  = CHAR_W'($urandom_range(8'h20, 8'h7E));
               if ($urandom_range(0, 29) == 0) ch = CHAR_LF;
            end else begin
               roll = $urandom_range(0, 99);
               if (roll < 50) begin
                  cmd = CMD_PUT_CHAR;
                  if ($urandom_range(0, 9) == 0) ch = $urandom_range(0, 1) ? CHAR_LF : CHAR_CR;
               end else if (roll < 63) begin
                  cmd = CMD_GOTO;
                  if ($urandom_range(0, 4) != 0) begin
                     col = IN_COL_W'($urandom_range(0, COLUMNS_PER_ROW - 1));
                     row = IN_ROW_W'($urandom_range(0, ROWS - 1));
                  end
               end else if (roll < 88) begin
                  // Many reads aim at the cursor line, where text was just written.
                  cmd = CMD_READ;
                  roll = $urandom_range(0, 99);
                  if (roll < 80) col = IN_COL_W'($urandom_range(0, COLUMNS_PER_ROW - 1));
                  if (roll < 45) row = IN_ROW_W'(cursor_y);
                  else if (roll < 80) row = IN_ROW_W'($urandom_range(0, ROWS - 1));
               end else if (roll < 91) begin
                  cmd = CMD_SCROLL_UP;
               end else if (roll < 94) begin
                  cmd = CMD_SCROLL_DOWN;
               end else if (roll < 96) begin
                  cmd = CMD_CLEAR;
               end else begin
                  cmd = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
               end
            end
            send_command(cmd, ch, col, row, 1'b0, '0);
         end
         req_ch.valid <= 1'b0;
      end

      settle();
      if (failures == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire
